// File: rtl/cfc_pkg.sv
// shared types, constants and the crc-32c byte step for the frame checker
`default_nettype none

package cfc_pkg;

    localparam int HEADER_BYTES   = 12;
    localparam int TRAILER_BYTES  = 4;
    localparam int OVERHEAD_BYTES = HEADER_BYTES + TRAILER_BYTES;
    localparam int ADDR_W         = 5;

    localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    localparam logic [2:0] REG_MAGIC   = 3'd0;
    localparam logic [2:0] REG_VERSION = 3'd1;
    localparam logic [2:0] REG_TYPE_MIN = 3'd2;
    localparam logic [2:0] REG_TYPE_MAX = 3'd3;
    localparam logic [2:0] REG_LIMIT   = 3'd4;

    localparam logic [31:0] MAL_MAGIC = 32'd1;
    localparam logic [31:0] MAL_TYPE  = 32'd2;
    localparam logic [31:0] MAL_FLAGS = 32'd3;

    typedef enum logic [2:0] {
        STATUS_OK,
        STATUS_TRUNCATED,
        STATUS_MALFORMED,
        STATUS_BAD_VERSION,
        STATUS_OVERSIZED,
        STATUS_CHECKSUM
    } cfc_status_t;

    typedef enum logic [2:0] {
        FAULT_NONE,
        FAULT_MAGIC,
        FAULT_VERSION,
        FAULT_TYPE,
        FAULT_FLAGS,
        FAULT_LENGTH
    } cfc_fault_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } cfc_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] detail;
        logic [7:0]  frame_type;
        logic [31:0] body_length;
        logic [32:0] consumed;
    } cfc_out_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  expected_version;
        logic [7:0]  type_min;
        logic [7:0]  type_max;
        logic [31:0] payload_limit;
    } cfc_cfg_t;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cfc_regs.sv
// apb configuration registers of the frame checker
`default_nettype none

module cfc_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cfc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output cfc_pkg::cfc_cfg_t                 cfg
);

    cfc_pkg::cfc_cfg_t cfg_reg;
    logic [2:0]        reg_index;
    logic              wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word       <= 32'd0;
            cfg_reg.expected_version <= 8'd0;
            cfg_reg.type_min         <= 8'd0;
            cfg_reg.type_max         <= 8'd4;
            cfg_reg.payload_limit    <= 32'd65536;
        end else if (wr_en) begin
            case (reg_index)
                cfc_pkg::REG_MAGIC:    cfg_reg.magic_word       <= pwdata;
                cfc_pkg::REG_VERSION:  cfg_reg.expected_version <= pwdata[7:0];
                cfc_pkg::REG_TYPE_MIN: cfg_reg.type_min         <= pwdata[7:0];
                cfc_pkg::REG_TYPE_MAX: cfg_reg.type_max         <= pwdata[7:0];
                cfc_pkg::REG_LIMIT:    cfg_reg.payload_limit    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            cfc_pkg::REG_MAGIC:    prdata = cfg_reg.magic_word;
            cfc_pkg::REG_VERSION:  prdata = {24'd0, cfg_reg.expected_version};
            cfc_pkg::REG_TYPE_MIN: prdata = {24'd0, cfg_reg.type_min};
            cfc_pkg::REG_TYPE_MAX: prdata = {24'd0, cfg_reg.type_max};
            cfc_pkg::REG_LIMIT:    prdata = cfg_reg.payload_limit;
            default:               prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/cfc_core.sv
// per-byte frame state, header checks, crc update and result decision
`default_nettype none

module cfc_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire cfc_pkg::cfc_in_t   item,
    input  wire cfc_pkg::cfc_cfg_t  cfg,
    output logic                    res_valid,
    output cfc_pkg::cfc_out_t       result
);

    logic [32:0]         byte_count_reg, byte_count_next;
    logic [31:0]         crc_reg, crc_next;
    logic [63:0]         header_reg, header_next;
    logic [31:0]         length_reg, length_next;
    logic [32:0]         end_reg, end_next;
    logic [31:0]         trailer_reg, trailer_next;
    cfc_pkg::cfc_fault_t pending_reg, pending_next;
    logic                decided_reg, decided_next;

    logic [32:0] idx, cnt, off;
    logic [7:0]  b;
    logic        in_header, in_crc, in_trailer, hdr_last;
    logic [7:0]  hdr_type;
    logic [31:0] crc_actual;
    cfc_pkg::cfc_fault_t fault;

    assign idx        = byte_count_reg;
    assign cnt        = idx + 33'd1;
    assign b          = item.data_byte;
    assign in_header  = idx < 33'(cfc_pkg::HEADER_BYTES);
    assign hdr_last   = idx == 33'(cfc_pkg::HEADER_BYTES - 1);
    assign in_crc     = in_header || (idx < end_reg);
    assign off        = idx - end_reg;
    assign in_trailer = !in_crc && (off[32:2] == 31'd0);
    assign hdr_type   = header_reg[47:40];
    assign crc_actual = crc_reg ^ cfc_pkg::CRC_PRESET;

    // header and length capture
    always_comb begin
        header_next = header_reg;
        length_next = length_reg;
        if (idx < 33'(cfc_pkg::HEADER_BYTES - 4)) begin
            header_next[{idx[2:0], 3'b000} +: 8] = b;
        end else if (in_header) begin
            length_next[{idx[1:0], 3'b000} +: 8] = b;
        end
    end

    always_comb begin
        trailer_next = trailer_reg;
        if (in_trailer) begin
            trailer_next[{off[1:0], 3'b000} +: 8] = b;
        end
    end

    assign crc_next = in_crc ? cfc_pkg::crc32c_byte(crc_reg, b) : crc_reg;
    assign end_next = hdr_last ? 33'(length_next) + 33'(cfc_pkg::HEADER_BYTES) : end_reg;

    // first failing header check wins
    always_comb begin
        if (header_next[31:0] != cfg.magic_word) begin
            fault = cfc_pkg::FAULT_MAGIC;
        end else if (header_next[39:32] != cfg.expected_version) begin
            fault = cfc_pkg::FAULT_VERSION;
        end else if ((header_next[47:40] < cfg.type_min) ||
                     (header_next[47:40] > cfg.type_max)) begin
            fault = cfc_pkg::FAULT_TYPE;
        end else if (header_next[63:48] != 16'd0) begin
            fault = cfc_pkg::FAULT_FLAGS;
        end else if (length_next > cfg.payload_limit) begin
            fault = cfc_pkg::FAULT_LENGTH;
        end else begin
            fault = cfc_pkg::FAULT_NONE;
        end
    end

    assign pending_next = hdr_last ? fault : pending_reg;

    always_comb begin
        res_valid = 1'b0;
        result    = '0;
        if (!decided_reg) begin
            if ((cnt == 33'(cfc_pkg::OVERHEAD_BYTES)) &&
                (pending_reg != cfc_pkg::FAULT_NONE)) begin
                res_valid = 1'b1;
                case (pending_reg)
                    cfc_pkg::FAULT_MAGIC: begin
                        result.status = cfc_pkg::STATUS_MALFORMED;
                        result.detail = cfc_pkg::MAL_MAGIC;
                    end
                    cfc_pkg::FAULT_VERSION: begin
                        result.status = cfc_pkg::STATUS_BAD_VERSION;
                        result.detail = {24'd0, header_reg[39:32]};
                    end
                    cfc_pkg::FAULT_TYPE: begin
                        result.status = cfc_pkg::STATUS_MALFORMED;
                        result.detail = cfc_pkg::MAL_TYPE;
                    end
                    cfc_pkg::FAULT_FLAGS: begin
                        result.status = cfc_pkg::STATUS_MALFORMED;
                        result.detail = cfc_pkg::MAL_FLAGS;
                    end
                    default: begin
                        result.status = cfc_pkg::STATUS_OVERSIZED;
                        result.detail = length_reg;
                    end
                endcase
            end else if ((pending_reg == cfc_pkg::FAULT_NONE) && in_trailer &&
                         (off[1:0] == 2'd3)) begin
                res_valid = 1'b1;
                if (crc_actual != trailer_next) begin
                    result.status = cfc_pkg::STATUS_CHECKSUM;
                    result.detail = crc_actual ^ trailer_next;
                end else begin
                    result.status      = cfc_pkg::STATUS_OK;
                    result.frame_type  = hdr_type;
                    result.body_length = length_reg;
                    result.consumed    = 33'(length_reg) +
                                         33'(cfc_pkg::OVERHEAD_BYTES);
                end
            end else if (item.last_byte) begin
                res_valid     = 1'b1;
                result.status = cfc_pkg::STATUS_TRUNCATED;
                result.detail = cnt[32] ? 32'hFFFF_FFFF : cnt[31:0];
            end
        end
    end

    assign byte_count_next = cnt;
    assign decided_next    = res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last_byte)) begin
            byte_count_reg <= 33'd0;
            crc_reg        <= cfc_pkg::CRC_PRESET;
            header_reg     <= 64'd0;
            length_reg     <= 32'd0;
            end_reg        <= 33'd0;
            trailer_reg    <= 32'd0;
            pending_reg    <= cfc_pkg::FAULT_NONE;
            decided_reg    <= 1'b0;
        end else if (step && !decided_reg) begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            header_reg     <= header_next;
            length_reg     <= length_next;
            end_reg        <= end_next;
            trailer_reg    <= trailer_next;
            pending_reg    <= pending_next;
            decided_reg    <= decided_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crc32c_frame_checker.sv
// top level of the crc-32c frame checker: input register, core, result register
`default_nettype none

// Checks byte-serial frames (12-byte header, payload, crc-32c trailer) and gives
// one result request per buffer. One byte is taken every clock cycle; the input
// stalls only while a result waits in the result register and m_ready is low. A
// byte passes an input register, the per-byte crc step and header checks, and a
// result register; a result enters the result register at the edge that takes
// the byte deciding it out of the input register. Throughput is set by the
// crc-32c byte update feeding back into the crc register. Configuration must be
// written over the apb port while the block is idle; the block does not enforce it.
module crc32c_frame_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire cfc_pkg::cfc_in_t             s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output cfc_pkg::cfc_out_t                 m_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cfc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    cfc_pkg::cfc_cfg_t cfg;
    cfc_pkg::cfc_in_t  in_data_reg;
    logic              in_valid_reg;
    cfc_pkg::cfc_out_t out_data_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              res_valid;
    cfc_pkg::cfc_out_t result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    cfc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_data_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_data_reg <= result;
        end
    end

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status <= 3'(cfc_pkg::STATUS_CHECKSUM)))
        else $error("result status out of range");

    a_ok_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == 3'(cfc_pkg::STATUS_OK))) |->
        (m_data.consumed == 33'(m_data.body_length) +
                            33'(cfc_pkg::OVERHEAD_BYTES)))
        else $error("ok result consumed does not match length");

    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != 3'(cfc_pkg::STATUS_OK))) |->
        ((m_data.frame_type == 8'd0) && (m_data.body_length == 32'd0) &&
         (m_data.consumed == 33'd0)))
        else $error("failed result carries frame fields");

    a_held_under_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("request dropped while result stalled");

endmodule

`default_nettype wire
